// ----- src/assert_macros.svh -----
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every edge outside reset
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// checked on every edge, reset included
`define PTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`else

`define PTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- src/pts_pkg.sv -----
package pts_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 2;
    localparam int ST_W    = 2;
    localparam int SIZE_W  = 9;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int DEF_MAX_STACK_DEPTH = 256;
    localparam int DEF_NUM_STACKS      = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET  = 9'd256;
    localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    // register index, taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_STACK_SIZE = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // memory command from control to entry store
    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_cmd;

endpackage

// ----- src/pts_regs.sv -----
module pts_regs
    import pts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [SIZE_W-1:0]  o_stack_size
);

    logic [SIZE_W-1:0] r_stack_size;
    logic              hit;

    assign hit = (paddr[PADDR_W-1:2] == REG_STACK_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_size <= SIZE_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_stack_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata       = hit ? PDATA_W'(r_stack_size) : '0;
    assign pready       = 1'b1;
    assign o_stack_size = r_stack_size;

endmodule

// ----- src/pts_store.sv -----
module pts_store
    import pts_pkg::*;
#(
    parameter int DEPTH = DEF_NUM_STACKS * DEF_MAX_STACK_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  t_mem_cmd          i_cmd,
    input  logic [AW-1:0]     i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pts_ctrl.sv -----
`include "assert_macros.svh"

module pts_ctrl
    import pts_pkg::*;
#(
    parameter int MAX_STACK_DEPTH = DEF_MAX_STACK_DEPTH,
    parameter int NUM_STACKS      = DEF_NUM_STACKS,
    parameter int AW              = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_stack_size,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [IDX_W-1:0]  i_stack_index,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_read_value,
    output logic [ST_W-1:0]   o_status,
    output t_mem_cmd          o_cmd,
    output logic [AW-1:0]     o_addr,
    input  logic [DATA_W-1:0] i_rdata
);

    localparam int CW   = $clog2(MAX_STACK_DEPTH + 1);
    localparam int SW   = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int SELW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int PW   = AW + IDX_W + 2;
    localparam logic [SW-1:0] MAX_V = SW'(MAX_STACK_DEPTH);

    logic [CW-1:0]     r_fill [NUM_STACKS];
    logic              r_valid;
    logic [DATA_W-1:0] r_value;
    t_status           r_status;
    logic              r_use_mem;

    logic              accept;
    logic              in_range;
    logic [SELW-1:0]   sel;
    logic [CW-1:0]     fill_cur;
    logic [SW-1:0]     size_ext;
    logic [SW-1:0]     size_eff;
    logic              full;
    logic [CW-1:0]     slot;
    logic [PW-1:0]     addr_full;
    t_opcode           op;
    t_mem_cmd          cmd;
    logic              fill_we;
    logic [CW-1:0]     n_fill;
    logic [DATA_W-1:0] n_value;
    t_status           n_status;
    logic              n_use_mem;
    logic              n_valid;

    assign o_ready  = !r_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign in_range = (32'(i_stack_index) < NUM_STACKS);
    assign sel      = SELW'(i_stack_index);
    assign fill_cur = in_range ? r_fill[sel] : '0;
    assign size_ext = SW'(i_stack_size);
    assign size_eff = (size_ext > MAX_V) ? MAX_V : size_ext;
    assign full     = (SW'(fill_cur) >= size_eff);
    assign op       = t_opcode'(i_opcode);

    // push lands on the count, pop and peek read one below it
    assign slot      = (op == OP_PUSH) ? fill_cur : fill_cur - CW'(1);
    assign addr_full = PW'(sel) * PW'(MAX_STACK_DEPTH) + PW'(slot);
    assign o_addr    = addr_full[AW-1:0];
    assign o_cmd     = cmd;

    always_comb begin
        cmd       = '0;
        fill_we   = 1'b0;
        n_fill    = fill_cur;
        n_value   = '0;
        n_status  = ST_OK;
        n_use_mem = 1'b0;
        case (op)
            OP_PUSH: begin
                if (!in_range || full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.wr  = accept;
                    fill_we = 1'b1;
                    n_fill  = fill_cur + CW'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (!in_range || fill_cur == '0) begin
                    n_value  = EMPTY_VALUE;
                    n_status = ST_EMPTY;
                end else begin
                    cmd.rd    = accept;
                    n_use_mem = 1'b1;
                    if (op == OP_POP) begin
                        fill_we = 1'b1;
                        n_fill  = fill_cur - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign n_valid = accept ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_fill[s] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            if (accept && fill_we) begin
                r_fill[sel] <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value   <= n_value;
            r_status  <= n_status;
            r_use_mem <= n_use_mem;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_use_mem ? i_rdata : r_value;
    assign o_status     = r_status;

    `PTS_ASSERT(a_rd_not_empty, i_clk, i_rst_n, cmd.rd |-> (fill_cur != '0), "read of an empty stack")
    `PTS_ASSERT(a_wr_below_size, i_clk, i_rst_n, cmd.wr |-> (SW'(fill_cur) < size_eff), "write past stack size")
    `PTS_ASSERT(a_cmd_on_accept, i_clk, i_rst_n, (cmd.wr || cmd.rd) |-> accept, "memory access without a beat")
    `PTS_ASSERT_ALWAYS(a_one_port_op, i_clk, !(cmd.wr && cmd.rd), "read and write in one cycle")

endmodule

// ----- src/partitioned_triple_stack.sv -----
// Stacks sharing one entry memory, NUM_STACKS fixed partitions of MAX_STACK_DEPTH
// entries each; the stack_size register (byte address 0, reset 256) caps how many
// entries each stack may hold, saturating at MAX_STACK_DEPTH. Each input beat
// carries an opcode (push, pop, peek, or a no-op code), a stack index and a push
// value, and gives exactly one result beat: read_value and status (ok, empty,
// full). One beat is accepted per clock while no result is held back; its result
// appears on the cycle after acceptance, and a pop or peek reads the memory as it is
// accepted, the single read/write port serving each beat's at most one access. Fill
// counts live in flip-flops and clear on reset at once, so there is no clearing
// pass; memory entries are undefined until pushed and are only ever read below the
// fill count. The input stalls only while a finished result is held and not being
// taken. Write stack_size only while the block is idle.
module partitioned_triple_stack
    import pts_pkg::*;
#(
    parameter int MAX_STACK_DEPTH = DEF_MAX_STACK_DEPTH,
    parameter int NUM_STACKS      = DEF_NUM_STACKS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // operation beats
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [IDX_W-1:0]   i_stack_index,
    input  logic [DATA_W-1:0]  i_push_value,
    // result beats
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DATA_W-1:0]  o_read_value,
    output logic [ST_W-1:0]    o_status
);

    // all partitions laid end to end in one memory
    localparam int DEPTH = NUM_STACKS * MAX_STACK_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [SIZE_W-1:0] stack_size;
    t_mem_cmd          mem_cmd;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_rdata;

    // stack_size register
    pts_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_stack_size (stack_size)
    );

    // fill counts, full and empty decisions, result register
    pts_ctrl #(
        .MAX_STACK_DEPTH (MAX_STACK_DEPTH),
        .NUM_STACKS      (NUM_STACKS),
        .AW              (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stack_size  (stack_size),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_stack_index (i_stack_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_cmd         (mem_cmd),
        .o_addr        (mem_addr),
        .i_rdata       (mem_rdata)
    );

    // entry memory, push value written straight from the input beat
    pts_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_cmd   (mem_cmd),
        .i_addr  (mem_addr),
        .i_wdata (i_push_value),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- test/tb_partitioned_triple_stack.sv -----
module tb_partitioned_triple_stack;
    import pts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DEPTH   = DEF_MAX_STACK_DEPTH;
    localparam int NSTACKS     = DEF_NUM_STACKS;
    localparam int CYCLE_LIMIT = 400000;

    // one operation beat as it goes onto the input ports
    typedef struct {
        t_opcode             op;
        logic [IDX_W-1:0]    idx;
        logic [DATA_W-1:0]   value;
    } t_op_beat;

    // one result beat as it should come back
    typedef struct {
        logic [DATA_W-1:0]   value;
        t_status             status;
    } t_result_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [OP_W-1:0]    i_opcode = '0;
    logic [IDX_W-1:0]   i_stack_index = '0;
    logic [DATA_W-1:0]  i_push_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [DATA_W-1:0]  o_read_value;
    logic [ST_W-1:0]    o_status;

    // shadow of the block: entries, fill levels and the size register
    logic [DATA_W-1:0]  stack_mem [NSTACKS*MAX_DEPTH];
    int unsigned        fill_level [NSTACKS];
    logic [SIZE_W-1:0]  size_reg = SIZE_RESET;

    t_op_beat           op_queue [$];
    t_result_beat       pending_results [$];

    int                 err_count = 0;
    int                 cycle_count = 0;
    int                 idle_mode = 0;
    int                 send_gap = 0;
    int                 stall_left = 0;
    bit                 beat_taken = 1'b0;

    partitioned_triple_stack dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_stack_index (i_stack_index),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status)
    );

    always #6 i_clk = ~i_clk;

    // what the block must answer to one operation, updating the shadow state
    function automatic t_result_beat stack_outcome(input t_opcode op,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [DATA_W-1:0] value);
        t_result_beat r;
        int unsigned  cap;
        int unsigned  base;
        r.value  = '0;
        r.status = ST_OK;
        // sizes above the partition depth saturate
        cap = (size_reg > MAX_DEPTH) ? MAX_DEPTH : size_reg;
        if (op == OP_NOP)
            return r;
        // a stack that does not exist looks full to a push, empty otherwise
        if (idx >= NSTACKS) begin
            if (op == OP_PUSH) begin
                r.status = ST_FULL;
            end else begin
                r.value  = EMPTY_VALUE;
                r.status = ST_EMPTY;
            end
            return r;
        end
        base = idx * MAX_DEPTH;
        if (op == OP_PUSH) begin
            // also covers a size lowered below the current fill
            if (fill_level[idx] >= cap) begin
                r.status = ST_FULL;
            end else begin
                stack_mem[base + fill_level[idx]] = value;
                fill_level[idx]++;
            end
        end else if (fill_level[idx] == 0) begin
            r.value  = EMPTY_VALUE;
            r.status = ST_EMPTY;
        end else begin
            r.value = stack_mem[base + fill_level[idx] - 1];
            if (op == OP_POP)
                fill_level[idx]--;
        end
        return r;
    endfunction

    // gap length: idle_mode 0 never idles, 1 lightly, 2 heavily
    function automatic int draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (idle_mode == 0)
            return 0;
        if (idle_mode == 1) begin
            if (roll < 65) return 0;
            if (roll < 92) return $urandom_range(1, 3);
            return $urandom_range(4, 25);
        end
        if (roll < 35) return 0;
        if (roll < 85) return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    // push data leaning on the sign and all-ones corners
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // driver: beats go out on the falling edge, acceptance seen on the rising
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
        // predict on acceptance, config never moves while beats are in flight
        if (i_rst_n && i_valid && o_ready) begin
            pending_results.insert(pending_results.size(),
                                   stack_outcome(t_opcode'(i_opcode), i_stack_index,
                                                 i_push_value));
            beat_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        t_op_beat nxt;
        // a beat still waiting keeps valid and payload as they are
        if (!i_valid || beat_taken) begin
            if (send_gap > 0) begin
                i_valid <= 1'b0;
                send_gap--;
            end else if (op_queue.size() > 0) begin
                nxt = op_queue.pop_front();
                i_opcode      <= nxt.op;
                i_stack_index <= nxt.idx;
                i_push_value  <= nxt.value;
                i_valid       <= 1'b1;
                send_gap      = draw_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    // ---------------------------------------------------------------------
    // monitor: back-pressure on the falling edge, results checked on the rising
    // ---------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
            stall_left = draw_gap();
        end
    end

    always @(posedge i_clk) begin
        t_result_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, got value %h status %0d",
                         $time, o_read_value, o_status);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.value) begin
                    $display("%0t: read_value mismatch, expected %h, got %h",
                             $time, want.value, o_read_value);
                    err_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_status);
                    err_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    task automatic queue_op(input t_opcode op, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] value);
        t_op_beat b;
        b.op    = op;
        b.idx   = idx;
        b.value = value;
        op_queue.insert(op_queue.size(), b);
    endtask

    // nothing queued, nothing on the port and every result back
    task automatic wait_idle();
        while (op_queue.size() > 0 || i_valid || pending_results.size() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // apb write of stack_size, then a read back of the raw register
    task automatic set_stack_size(input logic [SIZE_W-1:0] sz);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_STACK_SIZE, 2'b00};
        pwdata  <= {{(PDATA_W-SIZE_W){1'b0}}, sz};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        size_reg = sz;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[SIZE_W-1:0] !== sz) begin
            $display("%0t: stack_size read back mismatch, expected %0d, got %0d",
                     $time, sz, prdata[SIZE_W-1:0]);
            err_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random runs: push bursts, pop bursts, mixed runs and a little noise
    task automatic queue_random_ops(input int count);
        int n;
        int len;
        int kind;
        logic [IDX_W-1:0] idx;
        n = 0;
        while (n < count) begin
            idx  = IDX_W'($urandom_range(0, NSTACKS - 1));
            len  = $urandom_range(1, 12);
            kind = $urandom_range(0, 9);
            repeat (len) begin
                if (kind <= 3) begin
                    queue_op(OP_PUSH, idx, pick_value());
                    n++;
                end else if (kind <= 6) begin
                    queue_op(($urandom_range(0, 3) == 0) ? OP_PEEK : OP_POP, idx, $urandom);
                    n++;
                end else if (kind <= 8) begin
                    queue_op(t_opcode'($urandom_range(0, 2)), idx, pick_value());
                    n++;
                end else if ($urandom_range(0, 1) == 0) begin
                    // no-op code with any index, ignored by the block
                    queue_op(OP_NOP, IDX_W'($urandom_range(0, 3)), $urandom);
                end else begin
                    // absent fourth stack
                    queue_op(t_opcode'($urandom_range(0, 2)), 2'd3, $urandom);
                    n++;
                end
            end
        end
    endtask

    initial begin
        logic [SIZE_W-1:0] sizes [10];
        int                counts [10];

        sizes  = '{9'd1, 9'd0, 9'd511, 9'd3, 9'd256, 9'd2, 9'd255, 9'd7, 9'd0, 9'd256};
        counts = '{60, 40, 50, 60, 80, 60, 60, 60, 40, 60};
        foreach (fill_level[s])
            fill_level[s] = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty stacks, extreme values, every op, the missing stack
        idle_mode = 0;
        queue_op(OP_PEEK, 2'd0, '0);
        queue_op(OP_POP,  2'd0, '0);
        queue_op(OP_PUSH, 2'd0, 32'h7FFF_FFFF);
        queue_op(OP_PUSH, 2'd0, 32'h8000_0000);
        queue_op(OP_PEEK, 2'd0, '0);
        queue_op(OP_POP,  2'd0, '0);
        queue_op(OP_POP,  2'd0, '0);
        queue_op(OP_POP,  2'd0, '0);
        queue_op(OP_PUSH, 2'd1, 32'h0000_0000);
        queue_op(OP_PUSH, 2'd2, 32'hFFFF_FFFF);
        queue_op(OP_PUSH, 2'd1, 32'h5555_AAAA);
        queue_op(OP_PEEK, 2'd1, 32'hFFFF_FFFF);
        queue_op(OP_PUSH, 2'd3, 32'h1234_5678);
        queue_op(OP_POP,  2'd3, '0);
        queue_op(OP_PEEK, 2'd3, '0);
        queue_op(OP_NOP,  2'd3, 32'hFFFF_FFFF);
        queue_op(OP_NOP,  2'd0, '0);
        queue_op(OP_POP,  2'd2, '0);
        queue_op(OP_PEEK, 2'd2, '0);
        queue_op(OP_POP,  2'd1, '0);
        queue_op(OP_POP,  2'd1, '0);
        queue_op(OP_PUSH, 2'd2, 32'hAAAA_5555);
        queue_op(OP_PEEK, 2'd2, '0);
        wait_idle();

        // phases over several sizes, cycling through the three idling patterns
        foreach (sizes[p]) begin
            set_stack_size(sizes[p]);
            idle_mode = p % 3;
            // with the size saturated, walk stack 0 all the way to full
            if (sizes[p] > MAX_DEPTH) begin
                repeat (MAX_DEPTH + 4)
                    queue_op(OP_PUSH, 2'd0, pick_value());
                queue_op(OP_PEEK, 2'd0, '0);
            end
            queue_random_ops(counts[p]);
            wait_idle();
        end

        repeat (10) @(negedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
